// ===== src/rfp_pkg.sv =====
// Shared constants and the CRC-8 byte fold for the ranging frame parser.
package rfp_pkg;

    // Frame layout
    localparam int NUM_SECTORS = 8;
    localparam int DIST_BYTES  = 2 * NUM_SECTORS;
    localparam int FRAME_LEN   = DIST_BYTES + 4;
    localparam int DIST_FIRST  = 2;
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int DIST_IDX_W  = $clog2(DIST_BYTES);
    localparam int SEC_CNT_RAW = $clog2(NUM_SECTORS + 1);
    localparam int SEC_CNT_W   = (SEC_CNT_RAW > 3) ? SEC_CNT_RAW : 3;

    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_DIST_LO = POS_W'(DIST_FIRST);
    localparam logic [POS_W-1:0] POS_DIST_HI = POS_W'(DIST_FIRST + DIST_BYTES - 1);
    localparam logic [SEC_CNT_W-1:0] SEC_LAST = SEC_CNT_W'(NUM_SECTORS - 1);

    // Register map
    localparam int ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_CRC_POLY = 2'd0,
        REG_CRC_INIT = 2'd1,
        REG_SYNC     = 2'd2
    } t_reg_idx;

    localparam logic [7:0] CRC_POLY_RST = 8'h07;
    localparam logic [7:0] CRC_INIT_RST = 8'h00;
    localparam logic [7:0] SYNC_RST     = 8'h54;

    // Readings that mark no valid return
    localparam logic [15:0] DIST_NONE_HI = 16'hFFFF;
    localparam logic [15:0] DIST_NONE_LO = 16'h0000;
    localparam logic [15:0] DIST_NONE_1  = 16'h0001;

    // CRC-8, MSB first, no reflection, no final xor
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/ranging_frame_parser_crc8_unit.sv =====
// Top level: CRC-8 checked fixed-length ranging frame parser.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata[7:0] = rx_byte
//  m_axis    out  tdata[2:0] sector, [18:3] distance, [19] valid_res; tlast = last
//  apb       in   0x0 crc_polynomial, 0x4 crc_initial, 0x8 sync_byte
//
// One received byte is taken per cycle; s_axis_tready drops only when a check
// byte is due while the previous frame's results are still undelivered. A good
// frame puts out one result beat per cycle while m_axis_tready is high, from the
// cycle after its check byte, NUM_SECTORS beats in all, from a snapshot register
// that frees the byte store for the next frame. Reset (synchronous, active low)
// clears the frame position, the result queue and loads the register defaults.
module ranging_frame_parser_crc8_unit
    import rfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    // Result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [2:0] sector, [18:3] distance,
                                              // [19] valid_res, [23:20] zero
    output logic              m_axis_tlast,   // last
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Configuration registers
    logic [7:0] r_crc_poly;
    logic [7:0] r_crc_init;
    logic [7:0] r_sync;

    // Frame assembly state
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_crc;
    logic [7:0]       r_dist [DIST_BYTES];

    // Result queue
    logic                 r_busy;
    logic [SEC_CNT_W-1:0] r_sec;
    logic [15:0]          r_hold_dist [NUM_SECTORS];
    logic                 r_hold_ok   [NUM_SECTORS];

    logic                  n_pos_eff;
    logic [POS_W-1:0]      n_pos;
    logic [7:0]            n_crc_base;
    logic [7:0]            n_crc;
    logic [POS_W-1:0]      n_pos_rel;
    logic [DIST_IDX_W-1:0] n_dist_idx;
    logic                  n_store;
    logic                  n_good;
    logic                  in_beat;
    logic                  out_beat;
    logic                  cfg_wr;
    t_reg_idx              reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    // APB register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly <= CRC_POLY_RST;
            r_crc_init <= CRC_INIT_RST;
            r_sync     <= SYNC_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CRC_POLY: r_crc_poly <= pwdata[7:0];
                REG_CRC_INIT: r_crc_init <= pwdata[7:0];
                REG_SYNC:     r_sync     <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    // APB read mux
    always_comb begin
        case (reg_idx)
            REG_CRC_POLY: prdata = {24'd0, r_crc_poly};
            REG_CRC_INIT: prdata = {24'd0, r_crc_init};
            REG_SYNC:     prdata = {24'd0, r_sync};
            default:      prdata = 32'd0;
        endcase
    end

    // Handshakes: stall only a check byte that would need a busy queue
    assign s_axis_tready = !r_busy || (r_pos != POS_CHECK);
    assign in_beat       = s_axis_tvalid & s_axis_tready;
    assign out_beat      = m_axis_tvalid & m_axis_tready;

    // Per-byte frame logic: sync restart, CRC fold, store, check
    always_comb begin
        n_pos_eff  = (s_axis_tdata == r_sync);
        n_pos      = n_pos_eff ? '0 : r_pos;
        n_crc_base = (n_pos == '0) ? r_crc_init : r_crc;
        n_crc      = crc8_fold(n_crc_base, s_axis_tdata, r_crc_poly);
        n_pos_rel  = n_pos - POS_DIST_LO;
        n_dist_idx = n_pos_rel[DIST_IDX_W-1:0];
        n_store    = (n_pos >= POS_DIST_LO) && (n_pos <= POS_DIST_HI);
        n_good     = (n_pos == POS_CHECK) && (s_axis_tdata == r_crc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT_RST;
        end else if (in_beat) begin
            if (n_pos == POS_CHECK) begin
                r_pos <= '0;
            end else begin
                r_pos <= n_pos + POS_W'(1);
                r_crc <= n_crc;
            end
        end
    end

    // Distance byte store
    always_ff @(posedge i_clk) begin
        if (in_beat && n_store) begin
            r_dist[n_dist_idx] <= s_axis_tdata;
        end
    end

    // Result queue: load on a good frame, shift one sector per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sec  <= '0;
        end else if (in_beat && n_good) begin
            r_busy <= 1'b1;
            r_sec  <= '0;
        end else if (out_beat) begin
            if (r_sec == SEC_LAST) begin
                r_busy <= 1'b0;
            end
            r_sec <= r_sec + SEC_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && n_good) begin
            for (int k = 0; k < NUM_SECTORS; k++) begin
                r_hold_dist[k] <= {r_dist[2*k], r_dist[2*k+1]};
                r_hold_ok[k]   <= ({r_dist[2*k], r_dist[2*k+1]} != DIST_NONE_HI) &&
                                  ({r_dist[2*k], r_dist[2*k+1]} != DIST_NONE_LO) &&
                                  ({r_dist[2*k], r_dist[2*k+1]} != DIST_NONE_1);
            end
        end else if (out_beat) begin
            for (int k = 0; k < NUM_SECTORS - 1; k++) begin
                r_hold_dist[k] <= r_hold_dist[k+1];
                r_hold_ok[k]   <= r_hold_ok[k+1];
            end
        end
    end

    // Output beat
    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = {4'd0, r_hold_ok[0], r_hold_dist[0], r_sec[2:0]};
    assign m_axis_tlast  = (r_sec == SEC_LAST);

endmodule
